// ===== rtl/morse_element_player_top_assert.svh =====
// assertion macros for the element player
`ifndef MORSE_ELEMENT_PLAYER_TOP_ASSERT_SVH
`define MORSE_ELEMENT_PLAYER_TOP_ASSERT_SVH

// same-cycle implication
`define MEP_ASSERT_NOW(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define MEP_ASSERT_NEXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== rtl/mep_pkg.sv =====
`default_nettype none

package mep_pkg;

  localparam int MEP_MAX_ELEMENTS = 512;

  localparam int CODE_W  = 8;
  localparam int CFG_W   = 12;
  localparam int WPM_W   = 6;
  localparam int QUO_W   = 11;
  localparam int LEN_W   = 14;
  localparam int WAIT_W  = 18;
  localparam int PASS_W  = 8;

  localparam logic [QUO_W-1:0]  DIT_DIVIDEND = QUO_W'(1200);
  localparam logic [WAIT_W-1:0] PAUSE_TICKS  = WAIT_W'(100);
  localparam logic [WAIT_W-1:0] TONE_TRIM    = WAIT_W'(7);

  localparam logic [CODE_W-1:0] CODE_DIT   = 8'h31;
  localparam logic [CODE_W-1:0] CODE_DAH   = 8'h32;
  localparam logic [CODE_W-1:0] CODE_CGAP  = 8'h30;
  localparam logic [CODE_W-1:0] CODE_WGAP  = 8'h20;

  typedef enum logic [2:0] {
    MODE_CLEAR  = 3'd0,
    MODE_APPEND = 3'd1,
    MODE_START  = 3'd2,
    MODE_STOP   = 3'd3,
    MODE_TICK   = 3'd4
  } mode_t;

  typedef enum logic [1:0] {
    EV_NONE  = 2'd0,
    EV_START = 2'd1,
    EV_STOP  = 2'd2
  } tone_ev_t;

  typedef enum logic [2:0] {
    REG_WPM       = 3'd0,
    REG_DIT       = 3'd1,
    REG_DAH       = 3'd2,
    REG_CGAP      = 3'd3,
    REG_WGAP      = 3'd4,
    REG_RESUME    = 3'd5,
    REG_LOOP      = 3'd6,
    REG_PITCH     = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage

`default_nettype wire

// ===== rtl/mep_ram.sv =====
`default_nettype none

module mep_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 512
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/mep_div.sv =====
`default_nettype none

module mep_div import mep_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [WPM_W-1:0] divisor,
  output      div_status_t      status,
  output      logic [QUO_W-1:0] quotient
);

  localparam int CNT_W = $clog2(QUO_W);
  localparam logic [CNT_W-1:0] LAST = CNT_W'(QUO_W - 1);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [WPM_W-1:0] rem;
  logic [WPM_W-1:0] dvsr;
  logic [WPM_W:0]   trial;
  logic             fits;

  // one quotient bit per cycle, restoring
  assign trial = {rem, quotient[QUO_W-1]};
  assign fits  = trial >= {1'b0, dvsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + CNT_W'(1);
      if (cnt == LAST) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= '0;
      dvsr     <= divisor;
      quotient <= DIT_DIVIDEND;
    end else if (busy) begin
      rem      <= fits ? WPM_W'(trial - {1'b0, dvsr}) : trial[WPM_W-1:0];
      quotient <= {quotient[QUO_W-2:0], fits};
    end
  end

  assign status.busy = busy;
  assign status.done = busy && (cnt == LAST);

endmodule

`default_nettype wire

// ===== rtl/morse_element_player_top.sv =====
// channel | direction | handshake          | payload
// in      | into      | in_valid, in_stall | mode, element_code, mute
// out     | out of    | out_valid, out_stall | is_playing .. loop_count
// cfg     | into      | cfg_we             | cfg_index, cfg_data
//
// one item in flight: accept (element memory read registered), then the update in S_EXEC
// tick, clear, append, stop: S_IDLE, then S_EXEC, then the result beat register
// start: S_DIV between S_IDLE and S_EXEC, held for the 11-step serial divide for the dit length
// next item is taken once the result beat has left the output register
// synchronous reset; element memory needs no clearing pass
`default_nettype none

module morse_element_player_top import mep_pkg::*; #(
  parameter int MAX_ELEMENTS = MEP_MAX_ELEMENTS
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output      logic              in_stall,
  input  wire logic [2:0]        mode,
  input  wire logic [CODE_W-1:0] element_code,
  input  wire logic              mute,
  output      logic              out_valid,
  input  wire logic              out_stall,
  output      logic              is_playing,
  output      logic              tone_active,
  output      logic [1:0]        tone_event,
  output      logic [CFG_W-1:0]  tone_pitch,
  output      logic              char_done,
  output      logic              finished,
  output      logic [PASS_W-1:0] loop_count,
  input  wire logic              cfg_we,
  input  wire logic [2:0]        cfg_index,
  input  wire logic [CFG_W-1:0]  cfg_data
);

  localparam int ADDR_W = $clog2(MAX_ELEMENTS);
  localparam int POS_W  = $clog2(MAX_ELEMENTS + 1);
  localparam logic [POS_W-1:0] FULL = POS_W'(MAX_ELEMENTS);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_DIV  = 3'b010,
    S_EXEC = 3'b100
  } state_t;

  state_t state, state_next;

  logic [WPM_W-1:0] wpm;
  logic [CFG_W-1:0] dit_ticks, dah_ticks, cgap_ticks, wgap_ticks, pitch_hz;
  logic [3:0]       resume_dits;
  logic             loop_en;

  logic [2:0]        mode_q;
  logic [CODE_W-1:0] code_q;
  logic              mute_q;

  logic [POS_W-1:0]  stream_len, stream_len_next;
  logic [POS_W-1:0]  read_pos, read_pos_next;
  logic              playing, playing_next;
  logic              tone, tone_next;
  logic              paused, paused_next;
  logic [WAIT_W-1:0] wait_cnt, wait_cnt_next;
  logic [PASS_W-1:0] pass_cnt, pass_cnt_next;
  logic [QUO_W-1:0]  fixed_dit, fixed_dit_next;

  logic              in_accept, exec;
  logic              ram_we;
  logic [CODE_W-1:0] ram_rdata;
  div_status_t       div_st;
  logic [QUO_W-1:0]  div_quo;

  tone_ev_t          ev;
  logic [CFG_W-1:0]  pitch_o;
  logic              cdone, fin;

  logic              use_fixed;
  logic [LEN_W-1:0]  fd, dit_l, dah_l, cgap_l, wgap_l, tone_l;
  logic [WAIT_W-1:0] dit_w, wait_dec, resume_w, loop_w, tone_w;

  assign in_accept = in_valid && !in_stall;
  assign in_stall  = (state != S_IDLE) || out_valid;
  assign exec      = (state == S_EXEC);

  always_ff @(posedge clk) begin
    if (rst) begin
      wpm         <= '0;
      dit_ticks   <= CFG_W'(60);
      dah_ticks   <= CFG_W'(180);
      cgap_ticks  <= CFG_W'(120);
      wgap_ticks  <= CFG_W'(360);
      resume_dits <= '0;
      loop_en     <= 1'b0;
      pitch_hz    <= CFG_W'(700);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_WPM:    wpm         <= cfg_data[WPM_W-1:0];
        REG_DIT:    dit_ticks   <= cfg_data;
        REG_DAH:    dah_ticks   <= cfg_data;
        REG_CGAP:   cgap_ticks  <= cfg_data;
        REG_WGAP:   wgap_ticks  <= cfg_data;
        REG_RESUME: resume_dits <= cfg_data[3:0];
        REG_LOOP:   loop_en     <= cfg_data[0];
        REG_PITCH:  pitch_hz    <= cfg_data;
        default:    ;
      endcase
    end
  end

  mep_ram #(
    .WIDTH(CODE_W),
    .DEPTH(MAX_ELEMENTS)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(stream_len[ADDR_W-1:0]),
    .wdata(code_q),
    .re   (in_accept),
    .raddr(read_pos[ADDR_W-1:0]),
    .rdata(ram_rdata)
  );

  mep_div u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (in_accept && (mode == MODE_START)),
    .divisor (wpm),
    .status  (div_st),
    .quotient(div_quo)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_accept) begin
          state_next = (mode == MODE_START) ? S_DIV : S_EXEC;
        end
      end
      S_DIV: begin
        if (div_st.done) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC:  state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      mode_q <= mode;
      code_q <= element_code;
      mute_q <= mute;
    end
  end

  // element lengths, fixed speed or live registers
  assign use_fixed = (fixed_dit != '0);
  assign fd        = LEN_W'(fixed_dit);
  assign dit_l     = use_fixed ? fd : LEN_W'(dit_ticks);
  assign dah_l     = use_fixed ? fd + (fd << 1) : LEN_W'(dah_ticks);
  assign cgap_l    = use_fixed ? fd << 1 : LEN_W'(cgap_ticks);
  assign wgap_l    = use_fixed ? (fd << 2) + (fd << 1) : LEN_W'(wgap_ticks);
  assign tone_l    = (ram_rdata == CODE_DIT) ? dit_l : dah_l;

  assign dit_w    = WAIT_W'(dit_l);
  assign wait_dec = (wait_cnt != '0) ? wait_cnt - WAIT_W'(1) : '0;
  assign resume_w = WAIT_W'(resume_dits) * dit_w;
  assign loop_w   = WAIT_W'(wgap_l) + dit_w + (dit_w << 1);
  assign tone_w   = (WAIT_W'(tone_l) > TONE_TRIM) ? WAIT_W'(tone_l) - TONE_TRIM : '0;

  always_comb begin
    stream_len_next = stream_len;
    read_pos_next   = read_pos;
    playing_next    = playing;
    tone_next       = tone;
    paused_next     = paused;
    wait_cnt_next   = wait_cnt;
    pass_cnt_next   = pass_cnt;
    fixed_dit_next  = fixed_dit;
    ram_we          = 1'b0;
    ev              = EV_NONE;
    pitch_o         = '0;
    cdone           = 1'b0;
    fin             = 1'b0;
    unique case (mode_q)
      MODE_CLEAR: stream_len_next = '0;
      MODE_APPEND: begin
        if (stream_len < FULL) begin
          ram_we          = exec;
          stream_len_next = stream_len + POS_W'(1);
        end
      end
      MODE_START: begin
        fixed_dit_next = (wpm != '0) ? div_quo : '0;
        read_pos_next  = '0;
        playing_next   = 1'b1;
        tone_next      = 1'b0;
        paused_next    = 1'b0;
        wait_cnt_next  = '0;
        pass_cnt_next  = '0;
      end
      MODE_STOP: begin
        if (tone) begin
          tone_next = 1'b0;
          ev        = EV_STOP;
        end
        playing_next = 1'b0;
      end
      MODE_TICK: begin
        if (playing) begin
          wait_cnt_next = wait_dec;
          if (mute_q) begin
            if (tone) begin
              tone_next = 1'b0;
              ev        = EV_STOP;
            end
            paused_next   = 1'b1;
            wait_cnt_next = PAUSE_TICKS;
          end else if (paused && (resume_dits != '0)) begin
            paused_next   = 1'b0;
            wait_cnt_next = resume_w;
          end else begin
            paused_next = 1'b0;
            if (wait_dec != '0) begin
              wait_cnt_next = wait_dec;
            end else if (tone) begin
              tone_next     = 1'b0;
              ev            = EV_STOP;
              wait_cnt_next = (dit_w != '0) ? dit_w - WAIT_W'(1) : '0;
            end else if (read_pos >= stream_len) begin
              cdone = 1'b1;
              if (loop_en) begin
                pass_cnt_next = pass_cnt + PASS_W'(1);
                read_pos_next = '0;
                wait_cnt_next = loop_w;
              end else begin
                playing_next = 1'b0;
                fin          = 1'b1;
              end
            end else begin
              read_pos_next = read_pos + POS_W'(1);
              if ((ram_rdata == CODE_DIT) || (ram_rdata == CODE_DAH)) begin
                tone_next     = 1'b1;
                ev            = EV_START;
                pitch_o       = pitch_hz;
                wait_cnt_next = tone_w;
              end else if (ram_rdata == CODE_CGAP) begin
                wait_cnt_next = WAIT_W'(cgap_l);
                cdone         = 1'b1;
              end else if (ram_rdata == CODE_WGAP) begin
                wait_cnt_next = WAIT_W'(wgap_l);
                cdone         = 1'b1;
              end
            end
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stream_len <= '0;
      read_pos   <= '0;
      playing    <= 1'b0;
      tone       <= 1'b0;
      paused     <= 1'b0;
      wait_cnt   <= '0;
      pass_cnt   <= '0;
      fixed_dit  <= '0;
    end else if (exec) begin
      stream_len <= stream_len_next;
      read_pos   <= read_pos_next;
      playing    <= playing_next;
      tone       <= tone_next;
      paused     <= paused_next;
      wait_cnt   <= wait_cnt_next;
      pass_cnt   <= pass_cnt_next;
      fixed_dit  <= fixed_dit_next;
    end
  end

  // result beat register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (exec) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (exec) begin
      is_playing  <= playing_next;
      tone_active <= tone_next;
      tone_event  <= ev;
      tone_pitch  <= pitch_o;
      char_done   <= cdone;
      finished    <= fin;
      loop_count  <= pass_cnt_next;
    end
  end

`include "morse_element_player_top_assert.svh"

  `MEP_ASSERT_NOW(a_len_bound, clk, rst, 1'b1, stream_len <= FULL)
  `MEP_ASSERT_NOW(a_tone_needs_play, clk, rst, tone, playing)
  `MEP_ASSERT_NOW(a_fin_stops, clk, rst, out_valid && finished, !is_playing && !tone_active)
  `MEP_ASSERT_NEXT(a_exec_once, clk, rst, exec, (state == S_IDLE) && out_valid)
  `MEP_ASSERT_NOW(a_div_only_in_div, clk, rst, div_st.busy, state == S_DIV)

endmodule

`default_nettype wire

// ===== bench/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
  import mep_pkg::*;

  localparam logic [2:0] UNUSED_MODE_LO = 3'd5;
  localparam logic [2:0] UNUSED_MODE_HI = 3'd7;
  localparam int ADDR_W = $clog2(MEP_MAX_ELEMENTS);
  localparam int POS_W  = $clog2(MEP_MAX_ELEMENTS + 1);

  typedef struct {
    logic [2:0]        op;
    logic [CODE_W-1:0] code;
    logic              mute_bit;
  } player_beat_t;

  typedef struct packed {
    logic              playing;
    logic              tone;
    logic [1:0]        ev;
    logic [CFG_W-1:0]  pitch;
    logic              char_end;
    logic              stream_end;
    logic [PASS_W-1:0] passes;
  } player_status_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [2:0]        mode = MODE_CLEAR;
  logic [CODE_W-1:0] element_code = '0;
  logic              mute = 1'b0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic              is_playing;
  logic              tone_active;
  logic [1:0]        tone_event;
  logic [CFG_W-1:0]  tone_pitch;
  logic              char_done;
  logic              finished;
  logic [PASS_W-1:0] loop_count;
  logic              cfg_we = 1'b0;
  logic [2:0]        cfg_index = '0;
  logic [CFG_W-1:0]  cfg_data = '0;

  morse_element_player_top dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .mode         (mode),
    .element_code (element_code),
    .mute         (mute),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .is_playing   (is_playing),
    .tone_active  (tone_active),
    .tone_event   (tone_event),
    .tone_pitch   (tone_pitch),
    .char_done    (char_done),
    .finished     (finished),
    .loop_count   (loop_count),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #4 clk = ~clk;

  // player settings as last written
  logic [WPM_W-1:0] wpm_r = '0;
  logic [CFG_W-1:0] dit_r = CFG_W'(60);
  logic [CFG_W-1:0] dah_r = CFG_W'(180);
  logic [CFG_W-1:0] cgap_r = CFG_W'(120);
  logic [CFG_W-1:0] wgap_r = CFG_W'(360);
  logic [3:0]       resume_r = '0;
  logic             loop_r = 1'b0;
  logic [CFG_W-1:0] pitch_r = CFG_W'(700);

  // player state
  logic [CODE_W-1:0] elem_mem [MEP_MAX_ELEMENTS];
  logic [POS_W-1:0]  stream_len = '0;
  logic [POS_W-1:0]  read_pos = '0;
  logic              playing_now = 1'b0;
  logic              tone_now = 1'b0;
  logic              paused_now = 1'b0;
  logic [WAIT_W-1:0] wait_left = '0;
  logic [PASS_W-1:0] passes_now = '0;
  logic [QUO_W-1:0]  fixed_dit = '0;

  player_beat_t   pending [$];
  player_status_t expected [$];
  player_beat_t   beat;
  player_status_t want, got;

  int send_idle = 0;
  int recv_stall = 0;
  int hold_left = 0;
  int holds_asked = 0;
  int holds_done = 0;
  int mismatches = 0;
  int planned = 0;
  int phase_no = 0;

  function automatic logic [WAIT_W-1:0] dit_len();
    return (fixed_dit != 0) ? WAIT_W'(fixed_dit) : WAIT_W'(dit_r);
  endfunction

  function automatic logic [WAIT_W-1:0] wgap_len();
    return (fixed_dit != 0) ? WAIT_W'(fixed_dit) * WAIT_W'(6) : WAIT_W'(wgap_r);
  endfunction

  function automatic player_status_t advance_player(logic [2:0] op, logic [CODE_W-1:0] code,
                                                    logic mute_in);
    player_status_t s;
    logic [WAIT_W-1:0] tone_len;
    logic [CODE_W-1:0] c;
    s = '0;
    case (op)
      MODE_CLEAR: stream_len = '0;
      MODE_APPEND: begin
        if (stream_len < MEP_MAX_ELEMENTS) begin
          elem_mem[stream_len[ADDR_W-1:0]] = code;
          stream_len++;
        end
      end
      MODE_START: begin
        fixed_dit = (wpm_r != 0) ? DIT_DIVIDEND / QUO_W'(wpm_r) : '0;
        read_pos = '0;
        playing_now = 1'b1;
        tone_now = 1'b0;
        paused_now = 1'b0;
        wait_left = '0;
        passes_now = '0;
      end
      MODE_STOP: begin
        if (tone_now) begin
          tone_now = 1'b0;
          s.ev = EV_STOP;
        end
        playing_now = 1'b0;
      end
      MODE_TICK: begin
        if (playing_now) begin
          wait_left = (wait_left != 0) ? wait_left - 1'b1 : '0;
          if (mute_in) begin
            if (tone_now) begin
              tone_now = 1'b0;
              s.ev = EV_STOP;
            end
            paused_now = 1'b1;
            wait_left = PAUSE_TICKS;
          end else if (paused_now && resume_r != 0) begin
            paused_now = 1'b0;
            wait_left = WAIT_W'(resume_r) * dit_len();
          end else begin
            paused_now = 1'b0;
            if (wait_left != 0) begin
              // still counting down
            end else if (tone_now) begin
              tone_now = 1'b0;
              s.ev = EV_STOP;
              wait_left = (dit_len() > 1) ? dit_len() - 1'b1 : '0;
            end else if (read_pos >= stream_len) begin
              s.char_end = 1'b1;
              if (loop_r) begin
                passes_now++;
                read_pos = '0;
                wait_left = wgap_len() + dit_len() * WAIT_W'(3);
              end else begin
                playing_now = 1'b0;
                s.stream_end = 1'b1;
              end
            end else begin
              c = elem_mem[read_pos[ADDR_W-1:0]];
              read_pos++;
              if (c == CODE_DIT || c == CODE_DAH) begin
                tone_now = 1'b1;
                s.ev = EV_START;
                s.pitch = pitch_r;
                if (c == CODE_DIT) tone_len = dit_len();
                else tone_len = (fixed_dit != 0) ? WAIT_W'(fixed_dit) * WAIT_W'(3)
                                                 : WAIT_W'(dah_r);
                wait_left = (tone_len > TONE_TRIM) ? tone_len - TONE_TRIM : '0;
              end else if (c == CODE_CGAP) begin
                wait_left = (fixed_dit != 0) ? WAIT_W'(fixed_dit) * WAIT_W'(2)
                                             : WAIT_W'(cgap_r);
                s.char_end = 1'b1;
              end else if (c == CODE_WGAP) begin
                wait_left = wgap_len();
                s.char_end = 1'b1;
              end
            end
          end
        end
      end
      default: ;
    endcase
    s.playing = playing_now;
    s.tone = tone_now;
    s.passes = passes_now;
    return s;
  endfunction

  // sender
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) expected.push_back(advance_player(mode, element_code, mute));
      if (!in_valid || !in_stall) begin
        if (pending.size() != 0 && $urandom_range(99) >= send_idle) begin
          beat = pending.pop_front();
          in_valid <= 1'b1;
          mode <= beat.op;
          element_code <= beat.code;
          mute <= beat.mute_bit;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver and checker
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        got = {is_playing, tone_active, tone_event, tone_pitch, char_done, finished, loop_count};
        if (expected.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("result beat at %0t with nothing expected", $time);
        end else begin
          want = expected.pop_front();
          if (got.playing !== want.playing || got.tone !== want.tone || got.ev !== want.ev ||
              got.pitch !== want.pitch || got.char_end !== want.char_end ||
              got.stream_end !== want.stream_end || got.passes !== want.passes) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"mismatch at %0t (expected/got): playing %b/%b tone %b/%b ",
                        "event %0d/%0d pitch %0d/%0d char_done %b/%b finished %b/%b ",
                        "loops %0d/%0d"}, $time, want.playing, got.playing, want.tone,
                       got.tone, want.ev, got.ev, want.pitch, got.pitch, want.char_end,
                       got.char_end, want.stream_end, got.stream_end, want.passes, got.passes);
          end
        end
      end
      if (hold_left != 0) begin
        hold_left <= hold_left - 1;
      end else if (holds_done != holds_asked) begin
        holds_done <= holds_done + 1;
        hold_left <= 400;
      end
      out_stall <= (hold_left != 0) || ($urandom_range(99) < recv_stall);
    end
  end

  task automatic write_reg(reg_idx_t idx, logic [CFG_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      REG_WPM:    wpm_r = val[WPM_W-1:0];
      REG_DIT:    dit_r = val;
      REG_DAH:    dah_r = val;
      REG_CGAP:   cgap_r = val;
      REG_WGAP:   wgap_r = val;
      REG_RESUME: resume_r = val[3:0];
      REG_LOOP:   loop_r = val[0];
      REG_PITCH:  pitch_r = val;
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_regs(int wpm, int dit, int dah, int cgap, int wgap, int resume, int lp,
                          int pitch);
    write_reg(REG_WPM, CFG_W'(wpm));
    write_reg(REG_DIT, CFG_W'(dit));
    write_reg(REG_DAH, CFG_W'(dah));
    write_reg(REG_CGAP, CFG_W'(cgap));
    write_reg(REG_WGAP, CFG_W'(wgap));
    write_reg(REG_RESUME, CFG_W'(resume));
    write_reg(REG_LOOP, CFG_W'(lp));
    write_reg(REG_PITCH, CFG_W'(pitch));
  endtask

  task automatic wait_idle();
    do @(negedge clk); while (pending.size() != 0 || in_valid || expected.size() != 0);
  endtask

  task automatic next_phase();
    wait_idle();
    phase_no++;
    case (phase_no % 4)
      0: begin send_idle = 0;  recv_stall = 0;  end
      1: begin send_idle = 62; recv_stall = 0;  end
      2: begin send_idle = 0;  recv_stall = 62; end
      default: begin send_idle = 24; recv_stall = 24; end
    endcase
  endtask

  task automatic queue_beat(logic [2:0] op, logic [CODE_W-1:0] code, logic m);
    pending.push_back('{op, code, m});
    planned++;
  endtask

  function automatic logic [CODE_W-1:0] pick_code();
    case ($urandom_range(9))
      0, 1, 2: return CODE_DIT;
      3, 4:    return CODE_DAH;
      5, 6:    return CODE_CGAP;
      7:       return CODE_WGAP;
      default: return CODE_W'($urandom_range(255));
    endcase
  endfunction

  task automatic queue_stream(int n);
    repeat (n) queue_beat(MODE_APPEND, pick_code(), 1'($urandom_range(1)));
  endtask

  // mostly plain ticks, with muting and control beats sprinkled in
  task automatic queue_play(int n);
    int r;
    repeat (n) begin
      r = $urandom_range(999);
      if (r < 12) queue_beat(MODE_TICK, CODE_W'($urandom_range(255)), 1'b1);
      else if (r < 16) queue_beat(MODE_START, CODE_W'($urandom_range(255)), 1'($urandom_range(1)));
      else if (r < 19) queue_beat(MODE_STOP, CODE_W'($urandom_range(255)), 1'($urandom_range(1)));
      else if (r < 24) queue_beat(MODE_APPEND, pick_code(), 1'($urandom_range(1)));
      else if (r < 26) queue_beat(MODE_CLEAR, CODE_W'($urandom_range(255)), 1'($urandom_range(1)));
      else if (r < 28)
        queue_beat(3'($urandom_range(UNUSED_MODE_HI, UNUSED_MODE_LO)),
                   CODE_W'($urandom_range(255)), 1'($urandom_range(1)));
      else queue_beat(MODE_TICK, CODE_W'($urandom_range(255)), 1'b0);
    end
  endtask

  initial begin
    int m;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // directed: idle commands, every element kind, short tones, mute with resume gap
    set_regs(0, 1, 9, 0, 2, 1, 0, 4095);
    @(negedge clk);
    queue_beat(MODE_TICK, 8'h00, 1'b0);
    queue_beat(MODE_STOP, 8'hff, 1'b0);
    for (m = UNUSED_MODE_LO; m <= UNUSED_MODE_HI; m++) queue_beat(3'(m), 8'hff, 1'b1);
    queue_beat(MODE_CLEAR, 8'h00, 1'b0);
    queue_beat(MODE_APPEND, CODE_DIT, 1'b0);
    queue_beat(MODE_APPEND, CODE_DAH, 1'b1);
    queue_beat(MODE_APPEND, CODE_CGAP, 1'b0);
    queue_beat(MODE_APPEND, CODE_WGAP, 1'b0);
    queue_beat(MODE_APPEND, 8'hff, 1'b0);
    queue_beat(MODE_APPEND, 8'h00, 1'b0);
    queue_beat(MODE_START, 8'h00, 1'b0);
    repeat (3) queue_beat(MODE_TICK, 8'h00, 1'b0);
    queue_beat(MODE_TICK, 8'hff, 1'b1);
    repeat (7) queue_beat(MODE_TICK, 8'h00, 1'b0);
    queue_beat(MODE_START, 8'h00, 1'b0);
    queue_beat(MODE_TICK, 8'h00, 1'b0);
    queue_beat(MODE_STOP, 8'h00, 1'b0);

    // looping stream, sender waits for the block to drain halfway through
    next_phase();
    set_regs(0, 5, 14, 3, 8, 2, 1, 1234);
    queue_beat(MODE_CLEAR, 8'h00, 1'b0);
    queue_stream(10);
    queue_beat(MODE_START, 8'h00, 1'b0);
    queue_play(100);
    wait_idle();
    queue_play(150);

    // fastest fixed speed, longest resume gap, receiver holds off for a long stretch
    next_phase();
    set_regs(63, 4095, 4095, 4095, 4095, 15, 1, 0);
    queue_beat(MODE_CLEAR, 8'h00, 1'b0);
    queue_stream(8);
    queue_beat(MODE_START, 8'h00, 1'b0);
    holds_asked++;
    queue_play(250);

    // full store, extra appends dropped
    next_phase();
    set_regs(0, 1, 1, 0, 0, 0, 0, 2047);
    queue_beat(MODE_CLEAR, 8'h00, 1'b0);
    queue_stream(MEP_MAX_ELEMENTS + 2);
    queue_beat(MODE_START, 8'h00, 1'b0);
    queue_play(120);

    // slowest fixed speed, then longest register lengths
    next_phase();
    set_regs(1, 4095, 4095, 4095, 4095, 0, 0, 4095);
    queue_beat(MODE_CLEAR, 8'h00, 1'b0);
    queue_stream(4);
    queue_beat(MODE_START, 8'h00, 1'b0);
    queue_play(30);
    wait_idle();
    write_reg(REG_WPM, '0);
    queue_beat(MODE_START, 8'h00, 1'b0);
    queue_play(20);

    while (planned < 1600) begin
      next_phase();
      set_regs(($urandom_range(3) == 0) ? $urandom_range(63, 30) : 0, $urandom_range(15, 1),
               $urandom_range(40, 1), $urandom_range(20), $urandom_range(30),
               ($urandom_range(1) != 0) ? $urandom_range(15, 1) : 0, $urandom_range(1),
               $urandom_range(4095));
      if ($urandom_range(3) != 0) queue_beat(MODE_CLEAR, 8'h00, 1'($urandom_range(1)));
      queue_stream($urandom_range(16, 3));
      queue_beat(MODE_START, CODE_W'($urandom_range(255)), 1'($urandom_range(1)));
      queue_play($urandom_range(260, 120));
    end

    wait_idle();
    repeat (20) @(posedge clk);
    if (mismatches == 0 && expected.size() == 0) begin
      $display("morse_element_player_top regression: pass");
    end else begin
      $display("morse_element_player_top regression: fail");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("morse_element_player_top regression: fail");
    $finish;
  end

endmodule
